// File: rtl/cem_pkg.sv
// Package for the MIDI controller event mapper.
// Holds codes, field layouts, the state type and the structs passed between modules.
// No dependencies.
`default_nettype none

package cem_pkg;

	// Fixed MIDI geometry.
	localparam int MIDI_CHANNELS = 16;
	localparam int CONTROLLERS   = 128;
	localparam int SLOT_AW       = $clog2(MIDI_CHANNELS * CONTROLLERS);
	localparam int SLOT_DW       = 23;

	// Default sizes for the top level parameters.
	localparam int DEF_NUM_BINDINGS         = 16;
	localparam int DEF_CHANNELS_PER_BINDING = 2;

	// Message type nibbles.
	localparam logic [3:0] MT_NOTE_OFF = 4'h8;
	localparam logic [3:0] MT_NOTE_ON  = 4'h9;

	// Binding encodings.
	localparam logic [2:0] ENC_BUTTON = 3'd0;
	localparam logic [2:0] ENC_PAD    = 3'd1;
	localparam logic [2:0] ENC_REL_C  = 3'd2;
	localparam logic [2:0] ENC_REL_2C = 3'd3;
	localparam logic [2:0] ENC_ABS7   = 3'd4;
	localparam logic [2:0] ENC_ABS14  = 3'd5;
	localparam logic [2:0] ENC_REL14  = 3'd6;
	localparam logic [2:0] ENC_UNUSED = 3'd7;

	// Action codes that drive the modifier state.
	localparam logic [4:0] ACT_SHIFT     = 5'd4;
	localparam logic [4:0] ACT_JOG_TOUCH = 5'd9;

	// Event kinds and full-scale selectors.
	localparam logic [1:0] KIND_BUTTON = 2'd0;
	localparam logic [1:0] KIND_REL    = 2'd1;
	localparam logic [1:0] KIND_ABS    = 2'd2;
	localparam logic [1:0] FS_PLAIN    = 2'd0;
	localparam logic [1:0] FS_127      = 2'd1;
	localparam logic [1:0] FS_16383    = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	// Controller state machine.
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_EVAL  = 6'b001000,
		ST_SLOT  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// Outcome of testing one binding against the message.
	typedef struct packed {
		logic              hit;
		logic              emit;
		logic              slot;
		logic              is_msb;
		logic              rel;
		logic [4:0]        action;
		logic [1:0]        kind;
		logic [1:0]        deck;
		logic signed [14:0] value;
		logic [1:0]        fs;
		logic [7:0]        pad;
		logic [1:0]        shift_n;
		logic [1:0]        jog_n;
	} match_res_t;

	// Request for the 14-bit pair store.
	typedef struct packed {
		logic       is_msb;
		logic       rel;
		logic [6:0] d2;
	} slot_req_t;

	// Outcome of the 14-bit pair update.
	typedef struct packed {
		logic               emit;
		logic [1:0]         kind;
		logic signed [14:0] value;
		logic [1:0]         fs;
	} slot_res_t;

endpackage

`default_nettype wire

// File: rtl/cem_bind_ram.sv
// Binding table: two word memories read together through a registered read.
// Depends on nothing but its parameters.
`default_nettype none

module cem_bind_ram #(
	parameter int NUM_BINDINGS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic                                    wr_sel,
	input  wire logic [(NUM_BINDINGS > 1 ? $clog2(NUM_BINDINGS) : 1)-1:0] wr_addr,
	input  wire logic [63:0]                             wr_data,
	input  wire logic [(NUM_BINDINGS > 1 ? $clog2(NUM_BINDINGS) : 1)-1:0] rd_addr,
	output logic [63:0]                                  rd_w0,
	output logic [63:0]                                  rd_w1
);

	logic [63:0] mem0 [NUM_BINDINGS];
	logic [63:0] mem1 [NUM_BINDINGS];

	// One word written per command, both words read each cycle.
	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel) begin
			mem0[wr_addr] <= wr_data;
		end
		if (wr_en && wr_sel) begin
			mem1[wr_addr] <= wr_data;
		end
		rd_w0 <= mem0[rd_addr];
		rd_w1 <= mem1[rd_addr];
	end

endmodule

`default_nettype wire

// File: rtl/cem_match.sv
// Tests one binding against a MIDI message and forms the candidate event.
// Depends on cem_pkg.
`default_nettype none

module cem_match #(
	parameter int CHANNELS_PER_BINDING = cem_pkg::DEF_CHANNELS_PER_BINDING
) (
	input  wire logic [63:0]        w0,
	input  wire logic [63:0]        w1,
	input  wire logic [3:0]         mtype,
	input  wire logic [3:0]         ch,
	input  wire logic [6:0]         d1,
	input  wire logic [6:0]         d2,
	input  wire logic [1:0]         shift,
	input  wire logic [1:0]         jog,
	output cem_pkg::match_res_t     res
);

	logic [3:0]  tn;
	logic [2:0]  enc;
	logic [4:0]  act, sact, tact;
	logic        shv, tov, neg;
	logic [6:0]  base, lsb, centre;
	logic [7:0]  cnt, pad_off;
	logic [15:0] mask;
	logic [4:0]  below;
	logic [1:0]  deck, dmask, sh_n, jg_n;
	logic        type_ok, chan_ok, in_range, is14, is_lsb, deck_ok, pressed;
	logic        sh_act, touched;
	logic signed [8:0] dl;

	// Shift counts for deck zero when either deck holds it.
	function automatic logic shift_on(input logic [1:0] s, input logic [1:0] d);
		logic r;
		case (d)
			2'd0: r = |s;
			2'd1: r = s[0];
			2'd2: r = s[1];
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Field decode.
	assign tn      = w0[3:0];
	assign enc     = w0[6:4];
	assign act     = w0[11:7];
	assign shv     = w0[12];
	assign sact    = w0[17:13];
	assign tov     = w0[18];
	assign tact    = w0[23:19];
	assign base    = w0[30:24];
	assign cnt     = w0[38:31];
	assign lsb     = w0[45:39];
	assign centre  = w0[52:46];
	assign neg     = w0[53];
	assign pad_off = w1[7:0];
	assign mask    = w1[23:8];
	assign deck    = w1[24 + 2 * int'(ch) +: 2];

	// Member channels below this one; only the lowest CHANNELS_PER_BINDING member channels are honored.
	always_comb begin
		below = '0;
		for (int c = 0; c < 16; c++) begin
			if (c < int'(ch) && mask[c]) begin
				below = below + 5'd1;
			end
		end
	end

	assign chan_ok  = mask[ch] && (int'(below) < CHANNELS_PER_BINDING);
	assign type_ok  = (enc != cem_pkg::ENC_UNUSED) && ((mtype == tn) ||
		((tn == cem_pkg::MT_NOTE_ON) &&
		(mtype == cem_pkg::MT_NOTE_OFF || mtype == cem_pkg::MT_NOTE_ON)));
	assign in_range = (d1 >= base) && ({2'b0, d1} < ({2'b0, base} + {1'b0, cnt}));
	assign is14     = (enc == cem_pkg::ENC_ABS14) || (enc == cem_pkg::ENC_REL14);
	assign is_lsb   = is14 && (d1 == lsb);
	assign deck_ok  = (deck == 2'd1) || (deck == 2'd2);
	assign dmask    = (deck == 2'd2) ? 2'b10 : 2'b01;
	assign pressed  = (mtype != cem_pkg::MT_NOTE_OFF) && (d2 != 7'd0);

	// Modifier updates from shift and jog-touch buttons.
	always_comb begin
		sh_n = shift;
		jg_n = jog;
		if (enc == cem_pkg::ENC_BUTTON && deck_ok) begin
			if (act == cem_pkg::ACT_SHIFT) begin
				sh_n = pressed ? (shift | dmask) : (shift & ~dmask);
			end
			if (act == cem_pkg::ACT_JOG_TOUCH) begin
				jg_n = pressed ? (jog | dmask) : (jog & ~dmask);
			end
		end
	end

	assign sh_act  = shift_on(sh_n, deck) && shv;
	assign touched = deck_ok && ((jog & dmask) != 2'b00) && tov;

	// Relative delta, centred or two's complement, then direction.
	always_comb begin
		if (enc == cem_pkg::ENC_REL_2C) begin
			dl = d2[6] ? ($signed({2'b0, d2}) - 9'sd128) : $signed({2'b0, d2});
		end else begin
			dl = $signed({2'b0, d2}) - $signed({2'b0, centre});
		end
		if (neg) begin
			dl = -dl;
		end
	end

	// Candidate event by encoding.
	always_comb begin
		res         = '0;
		res.hit     = type_ok && chan_ok && (in_range || is_lsb);
		res.deck    = deck;
		res.shift_n = shift;
		res.jog_n   = jog;
		res.action  = act;
		case (enc)
			cem_pkg::ENC_BUTTON: begin
				res.shift_n = sh_n;
				res.jog_n   = jg_n;
				res.emit    = 1'b1;
				res.action  = sh_act ? sact : act;
				res.kind    = cem_pkg::KIND_BUTTON;
				res.value   = pressed ? 15'sd1 : 15'sd0;
			end
			cem_pkg::ENC_PAD: begin
				res.emit   = (mtype == cem_pkg::MT_NOTE_ON) && (d2 != 7'd0);
				res.action = sh_act ? sact : act;
				res.kind   = cem_pkg::KIND_BUTTON;
				res.value  = 15'sd1;
				res.pad    = {1'b0, d1} - {1'b0, base} + pad_off;
			end
			cem_pkg::ENC_REL_C, cem_pkg::ENC_REL_2C: begin
				res.emit   = (dl != 9'sd0);
				res.action = sh_act ? sact : (touched ? tact : act);
				res.kind   = cem_pkg::KIND_REL;
				res.value  = 15'(dl);
			end
			cem_pkg::ENC_ABS7: begin
				res.emit  = 1'b1;
				res.kind  = cem_pkg::KIND_ABS;
				res.value = $signed({8'b0, d2});
				res.fs    = cem_pkg::FS_127;
			end
			cem_pkg::ENC_ABS14, cem_pkg::ENC_REL14: begin
				res.slot   = 1'b1;
				res.is_msb = (d1 == base);
				res.rel    = (enc == cem_pkg::ENC_REL14);
			end
			default: begin
				res.hit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/cem_slot_ram.sv
// 14-bit pair store: MSB, pending mark, last position and its valid mark per slot.
// Depends on cem_pkg. Clears itself in one pass after reset.
`default_nettype none

module cem_slot_ram (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic                         wb,
	input  wire logic [cem_pkg::SLOT_AW-1:0]  addr,
	input  cem_pkg::slot_req_t                req,
	output logic                              clr_busy,
	output cem_pkg::slot_res_t                res
);

	localparam logic [cem_pkg::SLOT_AW-1:0] LAST = '1;

	logic [cem_pkg::SLOT_DW-1:0] mem [2**cem_pkg::SLOT_AW];
	logic [cem_pkg::SLOT_DW-1:0] rdata_s1, wdata;
	logic [cem_pkg::SLOT_AW-1:0] clr_q, waddr;
	logic                        clr_q_act, we, wneed;
	logic                        pend, had;
	logic [6:0]                  msb;
	logic [13:0]                 prev, comb;
	logic signed [15:0]          diff;

	// Clearing sweep, one slot a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q_act <= 1'b1;
			clr_q     <= '0;
		end else if (clr_q_act) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST) begin
				clr_q_act <= 1'b0;
			end
		end
	end

	assign clr_busy = clr_q_act;

	// Read-modify-write of one slot.
	assign pend = rdata_s1[22];
	assign msb  = rdata_s1[21:15];
	assign had  = rdata_s1[14];
	assign prev = rdata_s1[13:0];
	assign comb = {msb, req.d2};

	always_comb begin
		res   = '0;
		wneed = 1'b0;
		wdata = rdata_s1;
		diff  = $signed({2'b0, comb}) - $signed({2'b0, prev});
		if (diff > 16'sd8192) begin
			diff = diff - 16'sd16384;
		end else if (diff < -16'sd8192) begin
			diff = diff + 16'sd16384;
		end
		if (req.is_msb) begin
			wneed = 1'b1;
			wdata = {1'b1, req.d2, had, prev};
		end else if (pend) begin
			wneed = 1'b1;
			if (req.rel) begin
				wdata     = {1'b0, msb, 1'b1, comb};
				res.emit  = had && (diff != 16'sd0);
				res.kind  = cem_pkg::KIND_REL;
				res.value = 15'(diff);
				res.fs    = cem_pkg::FS_PLAIN;
			end else begin
				wdata     = {1'b0, msb, had, prev};
				res.emit  = 1'b1;
				res.kind  = cem_pkg::KIND_ABS;
				res.value = $signed({1'b0, comb});
				res.fs    = cem_pkg::FS_16383;
			end
		end
	end

	assign we    = clr_q_act || (wb && wneed);
	assign waddr = clr_q_act ? clr_q : addr;

	// Memory array, one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= clr_q_act ? '0 : wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/midi_controller_event_mapper.sv
// MIDI controller event mapper, top level.
// Depends on cem_pkg, cem_bind_ram, cem_match and cem_slot_ram.
//
// Usage:
// Input words arrive on in_valid/in_stall. A word with cmd set writes one
// 64-bit half of a binding entry while the mapper stays idle. A word with cmd
// clear is a MIDI message: the bindings are read one at a time from the
// binding memory, in a read state then a test state, until the first match or
// the binding count. A 14-bit binding adds a write-back state for the pair
// store, whose read overlaps the test, and a result passes through the output
// state.
// At most one result word leaves on out_valid/out_stall, held in an output
// register; while it waits, the next input word is taken, and only a second
// result waits for the register to empty.
// Configuration writes (cfg_valid/cfg_ready) are always taken.
// After reset the pair store is swept clear, with in_stall high.
// Reset also clears the configuration registers and shift and jog state.
`default_nettype none

module midi_controller_event_mapper #(
	parameter int NUM_BINDINGS         = cem_pkg::DEF_NUM_BINDINGS,
	parameter int CHANNELS_PER_BINDING = cem_pkg::DEF_CHANNELS_PER_BINDING
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration.
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [4:0]         cfg_data,
	// Input words.
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cmd,
	input  wire logic [7:0]         status_byte,
	input  wire logic [6:0]         first_data,
	input  wire logic [6:0]         second_data,
	input  wire logic [3:0]         entry_index,
	input  wire logic               word_select,
	input  wire logic [63:0]        word_value,
	// Result words.
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    event_valid,
	output logic [4:0]              action,
	output logic [1:0]              value_kind,
	output logic [1:0]              deck,
	output logic signed [14:0]      value,
	output logic [1:0]              full_scale,
	output logic [7:0]              pad_index
);

	localparam int AW = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;
	localparam int IW = $clog2(NUM_BINDINGS + 1);

	cem_pkg::state_t     state_q;
	cem_pkg::match_res_t mres;
	cem_pkg::slot_res_t  sres;
	cem_pkg::slot_req_t  sreq_q;

	logic                enable_q;
	logic [4:0]          count_q;
	logic [1:0]          shift_q, jog_q;
	logic [IW-1:0]       idx_q, lim, lim_q;
	logic [3:0]          mtype_q, ch_q;
	logic [6:0]          d1_q, d2_q;
	logic [63:0]         w0, w1;
	logic                in_acc, bind_we, clr_busy, out_free;
	logic [cem_pkg::SLOT_AW-1:0] slot_addr_q;

	logic [4:0]          ev_act_q;
	logic [1:0]          ev_kind_q, ev_deck_q, ev_fs_q;
	logic signed [14:0]  ev_val_q;
	logic [7:0]          ev_pad_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			count_q  <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == cem_pkg::CFG_ENABLE) begin
				enable_q <= cfg_data[0];
			end else begin
				count_q <= cfg_data;
			end
		end
	end

	// Input handshake and table writes.
	assign in_stall = (state_q != cem_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign bind_we  = in_acc && cmd && (int'(entry_index) < NUM_BINDINGS);
	assign lim      = (int'(count_q) > NUM_BINDINGS) ? IW'(NUM_BINDINGS) : IW'(count_q);
	assign out_free = !out_valid || !out_stall;

	cem_bind_ram #(
		.NUM_BINDINGS(NUM_BINDINGS)
	) u_bind (
		.clk     (clk),
		.wr_en   (bind_we),
		.wr_sel  (word_select),
		.wr_addr (AW'(entry_index)),
		.wr_data (word_value),
		.rd_addr (idx_q[AW-1:0]),
		.rd_w0   (w0),
		.rd_w1   (w1)
	);

	cem_match #(
		.CHANNELS_PER_BINDING(CHANNELS_PER_BINDING)
	) u_match (
		.w0    (w0),
		.w1    (w1),
		.mtype (mtype_q),
		.ch    (ch_q),
		.d1    (d1_q),
		.d2    (d2_q),
		.shift (shift_q),
		.jog   (jog_q),
		.res   (mres)
	);

	cem_slot_ram u_slot (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (state_q == cem_pkg::ST_EVAL),
		.wb       (state_q == cem_pkg::ST_SLOT),
		.addr     ((state_q == cem_pkg::ST_EVAL) ? {ch_q, w0[30:24]} : slot_addr_q),
		.req      (sreq_q),
		.clr_busy (clr_busy),
		.res      (sres)
	);

	// Sequencer: walk the bindings, then the pair store, then the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cem_pkg::ST_CLEAR;
			idx_q   <= '0;
			shift_q <= '0;
			jog_q   <= '0;
		end else begin
			case (state_q)
				cem_pkg::ST_CLEAR: begin
					if (!clr_busy) begin
						state_q <= cem_pkg::ST_IDLE;
					end
				end
				cem_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (in_acc && !cmd && enable_q && lim != '0) begin
						state_q <= cem_pkg::ST_READ;
					end
				end
				cem_pkg::ST_READ: begin
					state_q <= cem_pkg::ST_EVAL;
				end
				cem_pkg::ST_EVAL: begin
					if (mres.hit) begin
						shift_q <= mres.shift_n;
						jog_q   <= mres.jog_n;
						if (mres.slot) begin
							state_q <= cem_pkg::ST_SLOT;
						end else if (mres.emit) begin
							state_q <= cem_pkg::ST_OUT;
						end else begin
							state_q <= cem_pkg::ST_IDLE;
						end
					end else if (({1'b0, idx_q} + 1'b1) >= {1'b0, lim_q}) begin
						state_q <= cem_pkg::ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= cem_pkg::ST_READ;
					end
				end
				cem_pkg::ST_SLOT: begin
					state_q <= sres.emit ? cem_pkg::ST_OUT : cem_pkg::ST_IDLE;
				end
				cem_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= cem_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= cem_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Message and event holding registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mtype_q <= status_byte[7:4];
			ch_q    <= status_byte[3:0];
			d1_q    <= first_data;
			d2_q    <= second_data;
			lim_q   <= lim;
		end
		if (state_q == cem_pkg::ST_EVAL) begin
			ev_act_q    <= mres.action;
			ev_kind_q   <= mres.kind;
			ev_deck_q   <= mres.deck;
			ev_val_q    <= mres.value;
			ev_fs_q     <= mres.fs;
			ev_pad_q    <= mres.pad;
			slot_addr_q <= {ch_q, w0[30:24]};
			sreq_q      <= '{is_msb: mres.is_msb, rel: mres.rel, d2: d2_q};
		end
		if (state_q == cem_pkg::ST_SLOT) begin
			ev_kind_q <= sres.kind;
			ev_val_q  <= sres.value;
			ev_fs_q   <= sres.fs;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == cem_pkg::ST_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cem_pkg::ST_OUT && out_free) begin
			action     <= ev_act_q;
			value_kind <= ev_kind_q;
			deck       <= ev_deck_q;
			value      <= ev_val_q;
			full_scale <= ev_fs_q;
			pad_index  <= ev_pad_q;
		end
	end

	assign event_valid = 1'b1;

`ifndef SYNTH
	// A new result only comes from the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == cem_pkg::ST_OUT))
		else $error("result word without output state");

	// No input word is taken during the clearing sweep.
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall)
		else $error("input taken while pair store clears");

	// The pair store is only written back right after a binding test.
	a_slot_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cem_pkg::ST_SLOT |-> $past(state_q == cem_pkg::ST_EVAL))
		else $error("pair store update out of sequence");

	// The walk stays inside the table.
	a_idx_rng: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cem_pkg::ST_READ |-> int'(idx_q) < NUM_BINDINGS)
		else $error("binding index past table");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the MIDI controller event mapper.
// Drives binding writes and MIDI words, predicts each event in a local model.
// Depends on cem_pkg and midi_controller_event_mapper.
`timescale 1ns / 1ps

module testbench;

	localparam int NB = 16;
	localparam int CPB = 2;
	localparam int SLOTS = cem_pkg::MIDI_CHANNELS * cem_pkg::CONTROLLERS;

	// Message type nibbles used only for stimulus.
	localparam logic [3:0] MT_CC    = 4'hB;
	localparam logic [3:0] MT_PITCH = 4'hE;

	// One result word.
	typedef struct packed {
		logic [4:0]  act;
		logic [1:0]  kind;
		logic [1:0]  dk;
		logic [14:0] val;
		logic [1:0]  fs;
		logic [7:0]  pad;
	} evt_t;

	// One input word, with an optional typed-in expected result.
	typedef struct {
		logic        c;
		logic [7:0]  st;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [3:0]  idx;
		logic        ws;
		logic [63:0] wv;
		bit          chk;
		evt_t        want;
	} word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0, cfg_index = 0;
	logic [4:0] cfg_data = 0;
	logic cfg_ready;
	logic in_valid = 0, in_stall;
	logic cmd = 0, word_select = 0;
	logic [7:0] status_byte = 0;
	logic [6:0] first_data = 0, second_data = 0;
	logic [3:0] entry_index = 0;
	logic [63:0] word_value = 0;
	logic out_valid, out_stall = 0;
	logic event_valid;
	logic [4:0] action;
	logic [1:0] value_kind, deck, full_scale;
	logic signed [14:0] value;
	logic [7:0] pad_index;

	midi_controller_event_mapper dut (.*);

	always #4 clk = ~clk;

	// Local copy of the mapper state.
	logic [63:0] bind_w0 [NB];
	logic [63:0] bind_w1 [NB];
	logic        map_en;
	logic [4:0]  bind_cnt;
	logic [1:0]  shift_st, jog_st;
	logic [6:0]  msb_val [SLOTS];
	bit          msb_pend [SLOTS];
	logic [13:0] last_pos [SLOTS];
	bit          pos_known [SLOTS];

	evt_t events_due[$];
	int errors = 0;
	bit quiet_rx = 0;
	bit quiet_tx = 0;
	bit long_hold = 0;

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	function automatic bit shift_on(input logic [1:0] d);
		if (d == 0) return shift_st != 0;
		if (d == 3) return 0;
		return shift_st[d - 1];
	endfunction

	// Predicts the event a word causes and updates the local state.
	function automatic bit map_event(input word_t w, output evt_t e);
		logic [3:0] mt, ch;
		int n;
		e = '0;
		if (w.c) begin
			if (w.ws) bind_w1[w.idx] = w.wv;
			else bind_w0[w.idx] = w.wv;
			return 0;
		end
		if (!map_en) return 0;
		mt = w.st[7:4];
		ch = w.st[3:0];
		n = (bind_cnt > NB) ? NB : int'(bind_cnt);
		for (int i = 0; i < n; i++) begin
			logic [63:0] a, b;
			logic [2:0] enc;
			logic [4:0] act, sact, tact, chosen;
			logic [6:0] base, lsb, ctr;
			logic [7:0] cnt;
			logic [15:0] mask;
			logic [1:0] dk, m;
			bit note, pressed, deck_ok, touched;
			int below, delta, comb, slot;
			a = bind_w0[i];
			b = bind_w1[i];
			enc = a[6:4];
			act = a[11:7];
			sact = a[17:13];
			tact = a[23:19];
			base = a[30:24];
			cnt = a[38:31];
			lsb = a[45:39];
			ctr = a[52:46];
			if (enc == cem_pkg::ENC_UNUSED) continue;
			note = a[3:0] == cem_pkg::MT_NOTE_ON &&
				(mt == cem_pkg::MT_NOTE_ON || mt == cem_pkg::MT_NOTE_OFF);
			if (!note && mt != a[3:0]) continue;
			mask = b[23:8];
			if (!mask[ch]) continue;
			below = 0;
			for (int k = 0; k < ch; k++) below += mask[k];
			if (below >= CPB) continue;
			dk = b[24 + 2 * ch +: 2];
			if (!((w.d1 >= base && int'(w.d1) < int'(base) + int'(cnt)) ||
					((enc == cem_pkg::ENC_ABS14 || enc == cem_pkg::ENC_REL14) &&
					w.d1 == lsb))) continue;
			deck_ok = dk == 1 || dk == 2;
			e.dk = dk;
			case (enc)
				cem_pkg::ENC_BUTTON: begin
					pressed = mt != cem_pkg::MT_NOTE_OFF && w.d2 > 0;
					if (deck_ok) begin
						m = (dk == 2'd2) ? 2'b10 : 2'b01;
						if (act == cem_pkg::ACT_SHIFT)
							shift_st = pressed ? (shift_st | m) : (shift_st & ~m);
						if (act == cem_pkg::ACT_JOG_TOUCH)
							jog_st = pressed ? (jog_st | m) : (jog_st & ~m);
					end
					e.act = (shift_on(dk) && a[12]) ? sact : act;
					e.kind = cem_pkg::KIND_BUTTON;
					e.val = {14'd0, pressed};
					return 1;
				end
				cem_pkg::ENC_PAD: begin
					if (!(mt == cem_pkg::MT_NOTE_ON && w.d2 > 0)) return 0;
					e.act = (shift_on(dk) && a[12]) ? sact : act;
					e.kind = cem_pkg::KIND_BUTTON;
					e.val = 15'd1;
					e.pad = {1'b0, w.d1} - {1'b0, base} + b[7:0];
					return 1;
				end
				cem_pkg::ENC_REL_C, cem_pkg::ENC_REL_2C: begin
					if (enc == cem_pkg::ENC_REL_2C)
						delta = (w.d2 < 64) ? int'(w.d2) : int'(w.d2) - 128;
					else delta = int'(w.d2) - int'(ctr);
					if (a[53]) delta = -delta;
					if (delta == 0) return 0;
					touched = deck_ok && jog_st[dk - 1] && a[18];
					if (shift_on(dk) && a[12]) chosen = sact;
					else if (touched) chosen = tact;
					else chosen = act;
					e.act = chosen;
					e.kind = cem_pkg::KIND_REL;
					e.val = delta[14:0];
					return 1;
				end
				cem_pkg::ENC_ABS7: begin
					e.act = act;
					e.kind = cem_pkg::KIND_ABS;
					e.val = {8'd0, w.d2};
					e.fs = cem_pkg::FS_127;
					return 1;
				end
				default: begin
					slot = int'(ch) * cem_pkg::CONTROLLERS + int'(base);
					if (w.d1 == base) begin
						msb_val[slot] = w.d2;
						msb_pend[slot] = 1;
						return 0;
					end
					if (!msb_pend[slot]) return 0;
					msb_pend[slot] = 0;
					comb = int'({msb_val[slot], w.d2});
					e.act = act;
					if (enc == cem_pkg::ENC_REL14) begin
						bit had;
						had = pos_known[slot];
						delta = comb - int'(last_pos[slot]);
						last_pos[slot] = 14'(comb);
						pos_known[slot] = 1;
						if (!had) return 0;
						if (delta > 8192) delta -= 16384;
						if (delta < -8192) delta += 16384;
						if (delta == 0) return 0;
						e.kind = cem_pkg::KIND_REL;
						e.val = delta[14:0];
						return 1;
					end
					e.kind = cem_pkg::KIND_ABS;
					e.val = comb[14:0];
					e.fs = cem_pkg::FS_16383;
					return 1;
				end
			endcase
		end
		return 0;
	endfunction

	// Words to send, built up by the stimulus process.
	word_t send_q[$];

	// Sender: offers queued words with random gaps.
	initial begin
		word_t w;
		int gap;
		evt_t e;
		bit has, offer;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				has = map_event(w, e);
				if (w.chk) events_due.push_back(w.want);
				else if (has) events_due.push_back(e);
				offer = 1;
				if (!quiet_tx && $urandom_range(0, 5) == 0) begin
					in_valid <= 0;
					gap = $urandom_range(1, 18);
					repeat (gap) @(posedge clk);
				end
			end else begin
				offer = !in_valid;
			end
			if (offer) begin
				if (send_q.size() > 0) begin
					w = send_q.pop_front();
					in_valid <= 1;
					cmd <= w.c;
					status_byte <= w.st;
					first_data <= w.d1;
					second_data <= w.d2;
					entry_index <= w.idx;
					word_select <= w.ws;
					word_value <= w.wv;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (600) @(posedge clk);
				out_stall <= 0;
				long_hold = 0;
			end else if (!quiet_rx && $urandom_range(0, 7) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Checker: compares every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		evt_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{action, value_kind, deck, value, full_scale, pad_index};
			if (events_due.size() == 0) report("result word with nothing expected");
			else begin
				want = events_due.pop_front();
				if (!event_valid) report("event_valid low");
				if (got.act !== want.act)
					report($sformatf("action %0d want %0d", got.act, want.act));
				if (got.kind !== want.kind)
					report($sformatf("value_kind %0d want %0d", got.kind, want.kind));
				if (got.dk !== want.dk)
					report($sformatf("deck %0d want %0d", got.dk, want.dk));
				if (got.val !== want.val)
					report($sformatf("value %0h want %0h", got.val, want.val));
				if (got.fs !== want.fs)
					report($sformatf("full_scale %0d want %0d", got.fs, want.fs));
				if (got.pad !== want.pad)
					report($sformatf("pad_index %0d want %0d", got.pad, want.pad));
			end
		end
	end

	function automatic word_t midi(input logic [7:0] st, input logic [6:0] d1, d2);
		midi = '{c: 1'b0, st: st, d1: d1, d2: d2, idx: 4'd0, ws: 1'b0, wv: 64'd0,
			chk: 1'b0, want: '0};
	endfunction

	// Attaches a typed-in expected result to a word.
	function automatic word_t with_want(input word_t w, input evt_t v);
		with_want = w;
		with_want.chk = 1'b1;
		with_want.want = v;
	endfunction

	function automatic word_t bind_word(input int idx, input bit ws, input logic [63:0] v);
		bind_word = '{c: 1'b1, st: 8'($urandom), d1: 7'($urandom), d2: 7'($urandom),
			idx: 4'(idx), ws: ws, wv: v, chk: 1'b0, want: '0};
	endfunction

	// Random binding record; small ranges keep matches frequent.
	function automatic logic [63:0] rand_w0(input int enc);
		logic [63:0] v;
		logic [3:0] t;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: t = cem_pkg::MT_NOTE_ON;
			1: t = MT_CC;
			2: t = MT_PITCH;
			default: t = 4'($urandom);
		endcase
		v[3:0] = t;
		v[6:4] = 3'(enc);
		if ($urandom_range(0, 3) == 0) v[11:7] = cem_pkg::ACT_SHIFT;
		else if ($urandom_range(0, 3) == 0) v[11:7] = cem_pkg::ACT_JOG_TOUCH;
		v[30:24] = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
		v[38:31] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
		v[45:39] = 7'($urandom_range(0, 20));
		return v;
	endfunction

	function automatic logic [63:0] rand_w1();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0) v[23:8] = v[23:8] & 16'h000F;
		return v;
	endfunction

	task automatic wait_drain();
		while (send_q.size() > 0 || in_valid || events_due.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == cem_pkg::CFG_ENABLE) map_en = v[0];
		else bind_cnt = v;
	endtask

	// Directed stimulus table; some rows carry a typed-in expected result.
	word_t dir_tab[$];

	initial begin
		for (int i = 0; i < NB; i++) begin
			bind_w0[i] = 0;
			bind_w1[i] = 0;
		end
		map_en = 0;
		bind_cnt = 0;
		shift_st = 0;
		jog_st = 0;
		for (int i = 0; i < SLOTS; i++) begin
			msb_val[i] = 0;
			msb_pend[i] = 0;
			last_pos[i] = 0;
			pos_known[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed part: one binding per encoding on channels 0..1, rest empty.
		write_reg(cem_pkg::CFG_ENABLE, 5'd1);
		write_reg(cem_pkg::CFG_COUNT, 5'd31);
		for (int k = 0; k < NB; k++) begin
			logic [63:0] a, b;
			a = '0;
			b = '0;
			if (k < 8) begin
				a[3:0] = (k < 2) ? cem_pkg::MT_NOTE_ON : MT_CC;
				a[6:4] = 3'(k);
				a[11:7] = (k == 0) ? cem_pkg::ACT_SHIFT : 5'd31;
				a[12] = 1;
				a[17:13] = 5'd17;
				a[30:24] = 7'(10 * k);
				a[38:31] = 8'd4;
				a[45:39] = 7'(10 * k + 5);
				a[52:46] = 7'd64;
				b[7:0] = 8'hFF;
				b[23:8] = 16'h0003;
				b[27:24] = 4'b1001;
			end
			dir_tab.push_back(bind_word(k, 1'b0, a));
			dir_tab.push_back(bind_word(k, 1'b1, b));
		end
		dir_tab.push_back(with_want(midi(8'h90, 7'd0, 7'd127),
			'{5'd17, cem_pkg::KIND_BUTTON, 2'd1, 15'd1, cem_pkg::FS_PLAIN, 8'd0}));
		dir_tab.push_back(midi(8'h91, 7'd10, 7'd127));
		dir_tab.push_back(midi(8'h90, 7'd12, 7'd0));
		dir_tab.push_back(midi(8'hB0, 7'd20, 7'd0));
		dir_tab.push_back(midi(8'hB0, 7'd20, 7'd64));
		dir_tab.push_back(midi(8'hB1, 7'd30, 7'd127));
		dir_tab.push_back(with_want(midi(8'hB0, 7'd40, 7'd127),
			'{5'd31, cem_pkg::KIND_ABS, 2'd1, 15'd127, cem_pkg::FS_127, 8'd0}));
		dir_tab.push_back(midi(8'hB0, 7'd50, 7'd127));
		dir_tab.push_back(with_want(midi(8'hB0, 7'd55, 7'd127),
			'{5'd31, cem_pkg::KIND_ABS, 2'd1, 15'd16383, cem_pkg::FS_16383, 8'd0}));
		dir_tab.push_back(midi(8'hB0, 7'd60, 7'd0));
		dir_tab.push_back(midi(8'hB0, 7'd65, 7'd5));
		dir_tab.push_back(midi(8'hB0, 7'd60, 7'd127));
		dir_tab.push_back(midi(8'hB0, 7'd65, 7'd127));
		dir_tab.push_back(midi(8'h80, 7'd0, 7'd0));
		dir_tab.push_back(midi(8'hB0, 7'd70, 7'd1));
		foreach (dir_tab[r]) send_q.push_back(dir_tab[r]);
		wait_drain();

		// Random phases across register settings.
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(cem_pkg::CFG_ENABLE, {4'd0, ph != 3});
			write_reg(cem_pkg::CFG_COUNT, 5'(ph == 0 ? 0 : ph == 1 ? 16 : ph == 2 ? 31 :
				$urandom_range(1, 20)));
			quiet_tx = ph >= 8;
			quiet_rx = ph >= 8;
			if (ph == 4) long_hold = 1;
			for (int j = 0; j < 16; j++) begin
				send_q.push_back(bind_word(j, 1'b0, rand_w0($urandom_range(0, 7))));
				send_q.push_back(bind_word(j, 1'b1, rand_w1()));
			end
			for (int j = 0; j < 52; j++) begin
				logic [7:0] st;
				logic [6:0] d1;
				st = {($urandom_range(0, 2) == 0) ? cem_pkg::MT_NOTE_ON : MT_CC,
					4'($urandom_range(0, 3))};
				if ($urandom_range(0, 5) == 0) st = 8'($urandom);
				d1 = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 20));
				send_q.push_back(midi(st, d1, 7'($urandom)));
				if ($urandom_range(0, 2) == 0)
					send_q.push_back(midi(st, 7'($urandom_range(0, 20)), 7'($urandom)));
			end
			wait_drain();
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
